>>> rtl/ufbd_pkg.sv
// Shared types and constants for the UART fractional baud divider search.
// Used by the divider, datapath, controller and top level.
`default_nettype none

package ufbd_pkg;

    localparam int CLK_W          = 32;
    localparam int PCT_W          = 7;
    localparam int BAUD_W         = 24;
    localparam int DIVISOR_W      = 16;
    localparam int FRAC_W         = 4;
    localparam int ERR_W          = 17;
    localparam int CFG_IDX_W      = 1;

    localparam int PRESCALE_SHIFT = 6;
    localparam int UCLK_W         = CLK_W - PRESCALE_SHIFT;
    localparam int PROD_W         = UCLK_W + FRAC_W;

    // shared serial divider
    localparam int DIV_W          = 32;
    localparam int DVSR_W         = BAUD_W;
    localparam int SHORT_STEPS    = UCLK_W;
    localparam int CNT_W          = 5;

    localparam logic [FRAC_W-1:0]    MUL_MAX       = 4'd15;
    localparam logic [FRAC_W-1:0]    ADD_MAX       = 4'd15;
    localparam logic [FRAC_W-1:0]    MUL_FIRST     = 4'd1;
    localparam logic [FRAC_W-1:0]    ADD_FIRST     = 4'd0;
    localparam logic [ERR_W-1:0]     ERROR_START   = 17'd100000;
    localparam logic [DVSR_W-1:0]    PERCENT_BASE  = 24'd100;
    localparam logic [CLK_W-1:0]     CLOCK_RESET   = 32'd100000000;
    localparam logic [PCT_W-1:0]     PCT_RESET     = 7'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CORE_CLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_PCT    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_BASE,
        ST_BASE_WAIT,
        ST_QUO,
        ST_QUO_WAIT,
        ST_CHECK,
        ST_RATE,
        ST_RATE_WAIT,
        ST_UPDATE,
        ST_NEXT,
        ST_DONE
    } ufbd_state_t;

    typedef enum logic [1:0] {
        DSEL_BASE,
        DSEL_QUO,
        DSEL_RATE
    } ufbd_dsel_t;

    typedef struct packed {
        logic       load_item;
        logic       div_start;
        ufbd_dsel_t div_sel;
        logic       load_mul;
        logic       save_base;
        logic       save_quo;
        logic       save_dv;
        logic       save_rate;
        logic       update_best;
        logic       next_pair;
        logic       load_out;
    } ufbd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic baud_zero;
        logic dv_ok;
        logic better;
        logic err_zero;
        logic last_pair;
        logic out_free;
    } ufbd_status_t;

endpackage

`default_nettype wire

>>> rtl/ufbd_div.sv
// Restoring divider, one quotient bit per cycle, shared by every division.
// Depends on ufbd_pkg for widths.
`default_nettype none

module ufbd_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic                        short_op,
    input  wire logic [ufbd_pkg::DIV_W-1:0]  dividend,
    input  wire logic [ufbd_pkg::DVSR_W-1:0] divisor,
    output logic      [ufbd_pkg::DIV_W-1:0]  quotient,
    output logic      [ufbd_pkg::DVSR_W-1:0] remainder,
    output logic                             done
);
    import ufbd_pkg::*;

    logic [DIV_W-1:0]  quo_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;
    logic              ge;
    logic [DVSR_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, dvsr_reg};
        ge       = (trial >= {1'b0, dvsr_reg});
        rem_next = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // short operands sit left-aligned so fewer steps are needed
            if (short_op) begin
                quo_reg <= {dividend[SHORT_STEPS-1:0], (DIV_W-SHORT_STEPS)'(0)};
                cnt_reg <= CNT_W'(SHORT_STEPS - 1);
            end else begin
                quo_reg <= dividend;
                cnt_reg <= CNT_W'(DIV_W - 1);
            end
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

>>> rtl/ufbd_dp.sv
// Datapath: configuration registers, candidate pair, best-so-far and result register.
// Depends on ufbd_pkg and ufbd_div.
`default_nettype none

module ufbd_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic [ufbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ufbd_pkg::CLK_W-1:0]     cfg_data,
    input  wire logic [ufbd_pkg::BAUD_W-1:0]    s_baud_rate,
    input  wire ufbd_pkg::ufbd_cmd_t            cmd,
    output ufbd_pkg::ufbd_status_t              status,
    input  wire logic                           m_ready,
    output logic                                m_valid,
    output logic      [ufbd_pkg::DIVISOR_W-1:0] m_divisor,
    output logic      [ufbd_pkg::FRAC_W-1:0]    m_mul_val,
    output logic      [ufbd_pkg::FRAC_W-1:0]    m_div_add_val,
    output logic      [ufbd_pkg::ERR_W-1:0]     m_rate_error,
    output logic                                m_success
);
    import ufbd_pkg::*;

    logic [CLK_W-1:0]     clk_reg;
    logic [PCT_W-1:0]     pct_reg;

    logic [BAUD_W-1:0]    baud_reg;
    logic [FRAC_W-1:0]    m_reg;
    logic [FRAC_W-1:0]    a_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [UCLK_W-1:0]    base_reg;
    logic [UCLK_W-1:0]    q_reg;
    logic [BAUD_W-1:0]    r_reg;
    logic [DIVISOR_W-1:0] dv_reg;
    logic [UCLK_W-1:0]    rate_reg;

    logic [ERR_W-1:0]     best_err_reg;
    logic [DIVISOR_W-1:0] best_div_reg;
    logic [FRAC_W-1:0]    best_mul_reg;
    logic [FRAC_W-1:0]    best_add_reg;

    logic                 m_valid_reg;
    logic [DIVISOR_W-1:0] out_div_reg;
    logic [FRAC_W-1:0]    out_mul_reg;
    logic [FRAC_W-1:0]    out_add_reg;
    logic [ERR_W-1:0]     out_err_reg;
    logic                 out_succ_reg;

    logic [UCLK_W-1:0]       uclk;
    logic [BAUD_W+PCT_W-1:0] baud_pct;
    logic [BAUD_W+PCT_W-1:0] err_scaled;
    logic [FRAC_W:0]         frac_sum;
    logic [DIV_W-1:0]        div_dividend;
    logic [DVSR_W-1:0]       div_divisor;
    logic                    div_short;
    logic [DIV_W-1:0]        div_quo;
    logic [DVSR_W-1:0]       div_rem;
    logic                    div_done;

    logic                    round_up;
    logic [UCLK_W:0]         dv_full;
    logic [UCLK_W-1:0]       baud_ext;
    logic [UCLK_W-1:0]       err_full;

    assign uclk     = clk_reg[CLK_W-1:PRESCALE_SHIFT];
    assign baud_pct = baud_reg * pct_reg;
    // err < floor(baud*pct/100) holds exactly when 100*(err+1) <= baud*pct
    assign err_scaled = ((BAUD_W+PCT_W)'(best_err_reg) + 1'b1) *
                        (BAUD_W+PCT_W)'(PERCENT_BASE);
    assign frac_sum = {1'b0, m_reg} + {1'b0, a_reg};

    always_comb begin
        div_short = 1'b0;
        case (cmd.div_sel)
            DSEL_BASE: begin
                div_dividend = DIV_W'(prod_reg);
                div_divisor  = DVSR_W'(frac_sum);
            end
            DSEL_QUO: begin
                div_dividend = DIV_W'(base_reg);
                div_divisor  = baud_reg;
                div_short    = 1'b1;
            end
            DSEL_RATE: begin
                div_dividend = DIV_W'(base_reg);
                div_divisor  = DVSR_W'(dv_reg);
                div_short    = 1'b1;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    ufbd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .short_op  (div_short),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // round to nearest: bump when remainder exceeds half the baud rate
    always_comb begin
        round_up = (r_reg > {1'b0, baud_reg[BAUD_W-1:1]});
        dv_full  = {1'b0, q_reg} + (UCLK_W+1)'(round_up);
        baud_ext = UCLK_W'(baud_reg);
        err_full = (rate_reg >= baud_ext) ? (rate_reg - baud_ext) : (baud_ext - rate_reg);
    end

    always_comb begin
        status.div_done  = div_done;
        status.baud_zero = (baud_reg == '0);
        status.dv_ok     = (dv_full > (UCLK_W+1)'(2)) && (dv_full[UCLK_W:DIVISOR_W] == '0);
        status.better    = (err_full < UCLK_W'(best_err_reg));
        status.err_zero  = (err_full == '0);
        status.last_pair = (m_reg == MUL_MAX) && (a_reg == ADD_MAX);
        status.out_free  = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_reg <= CLOCK_RESET;
            pct_reg <= PCT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CORE_CLOCK: clk_reg <= cfg_data;
                REG_ERR_PCT:    pct_reg <= cfg_data[PCT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            baud_reg     <= s_baud_rate;
            m_reg        <= MUL_FIRST;
            a_reg        <= ADD_FIRST;
            best_err_reg <= ERROR_START;
            best_div_reg <= '0;
            best_mul_reg <= MUL_FIRST;
            best_add_reg <= ADD_FIRST;
        end
        if (cmd.load_mul) begin
            prod_reg <= m_reg * uclk;
        end
        if (cmd.save_base) begin
            base_reg <= div_quo[UCLK_W-1:0];
        end
        if (cmd.save_quo) begin
            q_reg <= div_quo[UCLK_W-1:0];
            r_reg <= div_rem;
        end
        if (cmd.save_dv) begin
            dv_reg <= dv_full[DIVISOR_W-1:0];
        end
        if (cmd.save_rate) begin
            rate_reg <= div_quo[UCLK_W-1:0];
        end
        if (cmd.update_best) begin
            best_err_reg <= err_full[ERR_W-1:0];
            best_div_reg <= dv_reg;
            best_mul_reg <= m_reg;
            best_add_reg <= a_reg;
        end
        if (cmd.next_pair) begin
            // add value inner, multiplier outer
            if (a_reg == ADD_MAX) begin
                a_reg <= ADD_FIRST;
                m_reg <= m_reg + 1'b1;
            end else begin
                a_reg <= a_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_div_reg  <= best_div_reg;
            out_mul_reg  <= best_mul_reg;
            out_add_reg  <= best_add_reg;
            out_err_reg  <= best_err_reg;
            out_succ_reg <= (baud_reg != '0) && (err_scaled <= baud_pct);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_divisor     = out_div_reg;
    assign m_mul_val     = out_mul_reg;
    assign m_div_add_val = out_add_reg;
    assign m_rate_error  = out_err_reg;
    assign m_success     = out_succ_reg;

endmodule

`default_nettype wire

>>> rtl/ufbd_ctrl.sv
// Controller: sequences the pair search and the divider for one item.
// Depends on ufbd_pkg.
`default_nettype none

module ufbd_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire ufbd_pkg::ufbd_status_t status,
    output ufbd_pkg::ufbd_cmd_t         cmd
);
    import ufbd_pkg::*;

    ufbd_state_t state_reg;
    ufbd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DSEL_BASE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                // zero baud: skip the search and report the defaults
                state_next = status.baud_zero ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                cmd.load_mul = 1'b1;
                state_next   = ST_BASE;
            end
            ST_BASE: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_BASE;
                state_next    = ST_BASE_WAIT;
            end
            ST_BASE_WAIT: begin
                if (status.div_done) begin
                    cmd.save_base = 1'b1;
                    state_next    = ST_QUO;
                end
            end
            ST_QUO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_QUO;
                state_next    = ST_QUO_WAIT;
            end
            ST_QUO_WAIT: begin
                if (status.div_done) begin
                    cmd.save_quo = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.save_dv = 1'b1;
                state_next  = status.dv_ok ? ST_RATE : ST_NEXT;
            end
            ST_RATE: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_RATE;
                state_next    = ST_RATE_WAIT;
            end
            ST_RATE_WAIT: begin
                if (status.div_done) begin
                    cmd.save_rate = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update_best = status.better;
                // stop on an exact match
                if (status.better && status.err_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                cmd.next_pair = 1'b1;
                state_next    = status.last_pair ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/uart_fractional_baud_divider_search_top.sv
// Top level of the UART fractional baud divider search: controller plus datapath.
// Depends on ufbd_pkg, ufbd_ctrl and ufbd_dp.
`default_nettype none

// For each requested baud rate the block tries the fractional pairs (multiplier 1..15,
// add value 0..15, multiplier outer) and returns the divisor, the pair, the absolute
// rate error and a success flag as one result item. One item at a time is searched.
// Every division runs through a single shared restoring divider that retires one
// quotient bit per cycle, and that divider sets the pace: each pair needs a 32-step
// division for the base clock and two 26-step divisions for divisor and achieved
// rate; a pair whose divisor is out of range skips the last one. A full search
// covers all 240 pairs; an exact match ends it at once, and a zero baud rate skips
// the search altogether. The acceptance bound is checked against a scaled error,
// with no division. A finished result waits in an output register, so the next
// item is taken while it is held.
// Configuration writes are taken in any cycle (cfg_ready stays high) and must only
// arrive while the block is idle.

module uart_fractional_baud_divider_search_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ufbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ufbd_pkg::CLK_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [ufbd_pkg::BAUD_W-1:0]    s_baud_rate,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [ufbd_pkg::DIVISOR_W-1:0] m_divisor,
    output logic      [ufbd_pkg::FRAC_W-1:0]    m_mul_val,
    output logic      [ufbd_pkg::FRAC_W-1:0]    m_div_add_val,
    output logic      [ufbd_pkg::ERR_W-1:0]     m_rate_error,
    output logic                                m_success
);
    import ufbd_pkg::*;

    ufbd_cmd_t    cmd;
    ufbd_status_t status;

    assign cfg_ready = 1'b1;

    ufbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ufbd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_baud_rate   (s_baud_rate),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_divisor     (m_divisor),
        .m_mul_val     (m_mul_val),
        .m_div_add_val (m_div_add_val),
        .m_rate_error  (m_rate_error),
        .m_success     (m_success)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result register loaded while an item still waits");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again before the search ran");

    a_div_not_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !status.div_done)
        else $error("divider reported done right after start");

    a_default_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_divisor == '0)) |-> ((m_mul_val == MUL_FIRST) &&
                                            (m_div_add_val == ADD_FIRST)))
        else $error("no divisor found but pair is not the default");

endmodule

`default_nettype wire

>>> test/uart_fractional_baud_divider_search_top_tb.sv
// Self-checking testbench for uart_fractional_baud_divider_search_top.
// Predicts each search result with its own divider model and checks every result item in order.
// Depends on ufbd_pkg and the block's RTL only.
`default_nettype none

module uart_fractional_baud_divider_search_top_tb;

    import ufbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int BAUD_MAX       = 16000000;
    localparam int NUM_STD_RATES  = 12;

    typedef struct packed {
        logic [DIVISOR_W-1:0] divisor;
        logic [FRAC_W-1:0]    mul_val;
        logic [FRAC_W-1:0]    div_add_val;
        logic [ERR_W-1:0]     rate_error;
        logic                 success;
    } baud_result_t;

    class divider_scoreboard;
        baud_result_t   divisor_q[$];
        logic [CLK_W-1:0] core_clock_hz;
        logic [PCT_W-1:0] err_pct;
        int             mismatches;

        function new();
            core_clock_hz = CLOCK_RESET;
            err_pct       = PCT_RESET;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CLK_W-1:0] data);
            if (idx == REG_CORE_CLOCK) begin
                core_clock_hz = data;
            end else if (idx == REG_ERR_PCT) begin
                err_pct = data[PCT_W-1:0];
            end
        endfunction

        function baud_result_t search_divisor(logic [BAUD_W-1:0] baud);
            longint unsigned uclk, baud_l, base, dv, rate, err, best_err, bound;
            baud_result_t    res;
            bit              exact;
            uclk            = longint'(core_clock_hz) >> PRESCALE_SHIFT;
            baud_l          = longint'(baud);
            res.divisor     = '0;
            res.mul_val     = MUL_FIRST;
            res.div_add_val = ADD_FIRST;
            best_err        = ERROR_START;
            exact           = 1'b0;
            if (baud_l != 0) begin
                for (int m = MUL_FIRST; m <= MUL_MAX && !exact; m++) begin
                    for (int a = ADD_FIRST; a <= ADD_MAX && !exact; a++) begin
                        base = (longint'(m) * uclk) / longint'(m + a);
                        dv   = base / baud_l;
                        // round up when the remainder passes half the baud rate
                        if ((base % baud_l) > (baud_l / 2)) dv++;
                        if (dv > 2 && dv < 65536) begin
                            rate = base / dv;
                            err  = (rate <= baud_l) ? (baud_l - rate) : (rate - baud_l);
                            if (err < best_err) begin
                                best_err        = err;
                                res.divisor     = dv[DIVISOR_W-1:0];
                                res.mul_val     = m[FRAC_W-1:0];
                                res.div_add_val = a[FRAC_W-1:0];
                                if (err == 0) exact = 1'b1;
                            end
                        end
                    end
                end
            end
            bound          = (baud_l * longint'(err_pct)) / longint'(PERCENT_BASE);
            res.rate_error = best_err[ERR_W-1:0];
            res.success    = (baud_l != 0) && (best_err < bound);
            return res;
        endfunction

        function void note_baud(logic [BAUD_W-1:0] baud);
            divisor_q.push_back(search_divisor(baud));
        endfunction

        function void check_result(baud_result_t got);
            baud_result_t exp;
            if (divisor_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result item: div=%0d mul=%0d add=%0d err=%0d ok=%0b",
                             got.divisor, got.mul_val, got.div_add_val, got.rate_error,
                             got.success);
                return;
            end
            exp = divisor_q.pop_front();
            if (got.divisor !== exp.divisor || got.mul_val !== exp.mul_val ||
                got.div_add_val !== exp.div_add_val || got.rate_error !== exp.rate_error ||
                got.success !== exp.success) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: exp div=%0d mul=%0d add=%0d err=%0d ok=%0b, got div=%0d mul=%0d add=%0d err=%0d ok=%0b",
                             exp.divisor, exp.mul_val, exp.div_add_val, exp.rate_error,
                             exp.success, got.divisor, got.mul_val, got.div_add_val,
                             got.rate_error, got.success);
            end
        endfunction

        function int pending();
            return divisor_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CLK_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [BAUD_W-1:0]    s_baud_rate;
    logic                 m_valid;
    logic                 m_ready;
    logic [DIVISOR_W-1:0] m_divisor;
    logic [FRAC_W-1:0]    m_mul_val;
    logic [FRAC_W-1:0]    m_div_add_val;
    logic [ERR_W-1:0]     m_rate_error;
    logic                 m_success;

    divider_scoreboard sb;
    int                send_idle;
    int                recv_idle;
    int                quiet_cycles;
    int unsigned       std_rates [NUM_STD_RATES] = '{300, 1200, 2400, 4800, 9600, 19200,
                                                     38400, 57600, 115200, 230400,
                                                     460800, 921600};

    uart_fractional_baud_divider_search_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_baud_rate   (s_baud_rate),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_divisor     (m_divisor),
        .m_mul_val     (m_mul_val),
        .m_div_add_val (m_div_add_val),
        .m_rate_error  (m_rate_error),
        .m_success     (m_success)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // receiver back-pressure, redrawn every cycle
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_divisor, m_mul_val, m_div_add_val, m_rate_error, m_success});
    end

    // end the run when no item has moved for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[uart_fractional_baud_divider_search_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // call at a falling edge; leaves valid high so back-to-back items need no second write
    task automatic send_baud(input logic [BAUD_W-1:0] baud);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_baud_rate <= baud;
        do @(posedge aclk); while (!s_ready);
        sb.note_baud(baud);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // drop the input and wait for every outstanding result before touching registers
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [CLK_W-1:0] clock_hz, input logic [PCT_W-1:0] pct);
        settle();
        write_reg(REG_CORE_CLOCK, clock_hz);
        write_reg(REG_ERR_PCT, {{(CLK_W-PCT_W){1'b0}}, pct});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BAUD_W-1:0] random_baud();
        case ($urandom_range(7))
            0:       return '0;
            1, 2:    return BAUD_W'(std_rates[$urandom_range(NUM_STD_RATES-1)]);
            3, 4:    return BAUD_W'($urandom_range(2000, 1));
            default: return BAUD_W'($urandom_range(BAUD_MAX));
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_baud(random_baud());
    endtask

    initial begin
        sb           = new();
        send_idle    = 31;
        recv_idle    = 55;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_baud_rate  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: zero rate, no candidate at all, exact hits and the range ends
        send_baud(0);
        send_baud(1);
        send_baud(2);
        send_baud(3);
        send_baud(10);
        send_baud(23);
        send_baud(24);
        send_baud(300);
        send_baud(9600);
        send_baud(115200);
        send_baud(520833);
        send_baud(781250);
        send_baud(1562500);
        send_baud(8388607);
        send_baud(BAUD_W'(BAUD_MAX));

        // fastest clock and a percentage above 100
        set_config(32'hFFFF_FFFF, 7'd127);
        send_baud(BAUD_W'(BAUD_MAX));
        send_baud(0);
        send_baud(1);
        send_baud(24'h40_0000);
        send_random(20);

        send_idle = 55;
        recv_idle = 31;
        // slowest clock: the prescaled clock is one, so nothing qualifies
        set_config(32'd64, 7'd0);
        send_baud(9600);
        send_baud(1);
        send_random(6);

        set_config(32'd12000000, 7'd100);
        send_random(20);

        send_idle = 0;
        recv_idle = 0;
        set_config($urandom_range(32'hFFFF_FFFF, 64), PCT_W'($urandom_range(127)));
        send_random(32);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[uart_fractional_baud_divider_search_top] OK");
        end else begin
            $display("[uart_fractional_baud_divider_search_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/ufbd_pkg.sv
rtl/ufbd_div.sv
rtl/ufbd_dp.sv
rtl/ufbd_ctrl.sv
rtl/uart_fractional_baud_divider_search_top.sv
test/uart_fractional_baud_divider_search_top_tb.sv
